// File: sv/flha_pkg.sv
package flha_pkg;

	localparam int HEAP_UNITS = 8192;
	localparam int UNIT_BYTES = 16;
	localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
	localparam int ADDR_W     = $clog2(HEAP_UNITS);
	localparam int SIZE_W     = ADDR_W + 1;
	localparam int WALK_LIMIT = 2 * HEAP_UNITS + 4;
	localparam int CNT_W      = $clog2(WALK_LIMIT + 1);
	localparam int BYTES_W    = 16;
	localparam int PADDR_W    = 3;

	localparam logic [BYTES_W-1:0] MAX_REQ_RST  = 16'd10240;
	localparam logic [SIZE_W-1:0]  MIN_GROW_RST = 14'd1024;

	localparam logic REG_MAX_REQ  = 1'b0;
	localparam logic REG_MIN_GROW = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TOO_BIG  = 2'd1;
	localparam logic [1:0] ST_OOM      = 2'd2;
	localparam logic [1:0] ST_BAD_FREE = 2'd3;

	typedef struct packed {
		logic [ADDR_W-1:0] nxt;
		logic [SIZE_W-1:0] size;
	} entry_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLR,
		OP_LOAD,
		OP_ALLOC,
		OP_AR,
		OP_AN,
		OP_AW,
		OP_S2,
		OP_G2,
		OP_FREE,
		OP_R0,
		OP_R1,
		OP_WALK,
		OP_M2,
		OP_M3
	} op_t;

	typedef struct packed {
		op_t  op;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic act;
		logic too_big;
		logic zero_ua;
		logic fit;
		logic exact;
		logic at_rover;
		logic grow_ok;
		logic split_in;
		logic step_lim;
		logic lim;
		logic bad_hdr;
		logic brk;
		logic walk_lim;
		logic ret;
		logic clr_last;
	} stat_t;

endpackage

// File: sv/flha_if.sv
interface flha_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [15:0] request_bytes;
	logic [12:0] user_address;

	modport source(output valid, action, request_bytes, user_address, input ready);
	modport sink(input valid, action, request_bytes, user_address, output ready);
endinterface

interface flha_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [12:0] granted_address;

	modport source(output valid, status, granted_address, input ready);
	modport sink(input valid, status, granted_address, output ready);
endinterface

// File: sv/flha_ctrl.sv
module flha_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  flha_pkg::stat_t st,
	output flha_pkg::cmd_t  cmd
);
	import flha_pkg::*;

	typedef enum logic [15:0] {
		S_CLR   = 16'h0001,
		S_IDLE  = 16'h0002,
		S_ALLOC = 16'h0004,
		S_AR    = 16'h0008,
		S_AN    = 16'h0010,
		S_AW    = 16'h0020,
		S_S2    = 16'h0040,
		S_G2    = 16'h0080,
		S_FREE  = 16'h0100,
		S_R0    = 16'h0200,
		S_R1    = 16'h0400,
		S_WALK  = 16'h0800,
		S_M2    = 16'h1000,
		S_M3    = 16'h2000,
		S_DONE  = 16'h4000
	} state_t;

	state_t state_q, state_d;
	logic   ov_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ov_q;

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		cmd.fin = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.op = OP_CLR;
				if (st.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = st.act ? S_FREE : S_ALLOC;
				end
			end
			S_ALLOC: begin
				cmd.op  = OP_ALLOC;
				state_d = st.too_big ? S_DONE : S_AN;
			end
			S_AR: begin
				cmd.op  = OP_AR;
				state_d = S_AN;
			end
			S_AN: begin
				cmd.op  = OP_AN;
				state_d = st.lim ? S_DONE : S_AW;
			end
			S_AW: begin
				cmd.op = OP_AW;
				if (st.fit) state_d = (!st.exact && st.split_in) ? S_S2 : S_DONE;
				else if (st.at_rover) state_d = st.grow_ok ? S_G2 : S_DONE;
				else if (st.step_lim) state_d = S_DONE;
			end
			S_S2: begin
				cmd.op  = OP_S2;
				state_d = S_DONE;
			end
			S_G2: begin
				cmd.op  = OP_G2;
				state_d = S_R0;
			end
			S_FREE: begin
				cmd.op  = OP_FREE;
				state_d = st.zero_ua ? S_DONE : S_R1;
			end
			S_R0: begin
				cmd.op  = OP_R0;
				state_d = S_R1;
			end
			S_R1: begin
				cmd.op = OP_R1;
				if (st.bad_hdr) state_d = st.ret ? S_AR : S_DONE;
				else state_d = S_WALK;
			end
			S_WALK: begin
				cmd.op = OP_WALK;
				if (st.brk) state_d = S_M2;
				else if (st.walk_lim) state_d = st.ret ? S_AR : S_DONE;
			end
			S_M2: begin
				cmd.op  = OP_M2;
				state_d = S_M3;
			end
			S_M3: begin
				cmd.op  = OP_M3;
				state_d = st.ret ? S_AR : S_DONE;
			end
			S_DONE: begin
				if (!ov_q || out_ready) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

endmodule

// File: sv/flha_dp.sv
module flha_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  flha_pkg::cmd_t                  cmd,
	output flha_pkg::stat_t                 st,
	input  logic                            in_action,
	input  logic [flha_pkg::BYTES_W-1:0]    in_bytes,
	input  logic [flha_pkg::ADDR_W-1:0]     in_ua,
	input  logic [flha_pkg::BYTES_W-1:0]    max_req,
	input  logic [flha_pkg::SIZE_W-1:0]     min_grow,
	output logic [1:0]                      out_status,
	output logic [flha_pkg::ADDR_W-1:0]     out_addr
);
	import flha_pkg::*;

	localparam int PW = ADDR_W + 2;

	entry_t mem [HEAP_UNITS];
	entry_t rd_q;
	logic              we;
	logic [ADDR_W-1:0] waddr, raddr;
	entry_t            wdata;

	// control state
	logic [ADDR_W-1:0] rover_q, clr_q;
	logic [SIZE_W-1:0] brk_q, lg_q;
	logic [CNT_W-1:0]  kw_q, kr_q;
	logic              ret_q, lim_q;

	// per-request working registers
	logic [BYTES_W-1:0] bytes_q;
	logic [ADDR_W-1:0]  ua_q, n_q, p_q, prev_q, h_q, hn_q, rp_q, q_q;
	logic [SIZE_W-1:0]  hs_q, ps_q, nu_q, prev_sz_q;
	logic [PW-1:0]      np_q;
	logic [1:0]         st_q, out_st_q;
	logic [ADDR_W-1:0]  ga_q, out_ga_q;

	logic [BYTES_W:0]   rnd;
	logic [ADDR_W-1:0]  nunits;
	logic [SIZE_W-1:0]  n14, diff, nu;
	logic [PW-1:0]      newp, gsum;
	logic [ADDR_W-1:0]  q;
	logic               hi_merge, lo_merge;
	logic [SIZE_W-1:0]  m_size;
	logic [ADDR_W-1:0]  m_next;

	assign rnd    = {1'b0, bytes_q} + (BYTES_W+1)'(UNIT_BYTES - 1);
	assign nunits = ADDR_W'(rnd >> UNIT_SHIFT) + ADDR_W'(1);
	assign n14    = {1'b0, n_q};
	assign diff   = rd_q.size - n14;
	assign newp   = {2'b00, p_q} + {1'b0, diff};
	assign nu     = (n14 < min_grow) ? min_grow : n14;
	assign gsum   = {1'b0, brk_q} + {1'b0, nu};
	assign q      = rd_q.nxt;

	assign hi_merge = ({2'b00, h_q} + {1'b0, hs_q}) == {2'b00, q_q};
	assign lo_merge = ({2'b00, rp_q} + {1'b0, ps_q}) == {2'b00, h_q};
	assign m_size   = hi_merge ? (hs_q + rd_q.size) : hs_q;
	assign m_next   = hi_merge ? rd_q.nxt : q_q;

	always_comb begin
		st.act      = in_action;
		st.too_big  = bytes_q > max_req;
		st.zero_ua  = (ua_q == '0);
		st.fit      = rd_q.size >= n14;
		st.exact    = rd_q.size == n14;
		st.at_rover = (p_q == rover_q);
		st.grow_ok  = gsum <= PW'(HEAP_UNITS);
		st.split_in = (newp[PW-1:ADDR_W] == '0);
		st.step_lim = (kw_q >= CNT_W'(WALK_LIMIT - 1));
		st.lim      = lim_q;
		st.bad_hdr  = (rd_q.size == '0) || (rd_q.size > lg_q);
		st.brk      = ((h_q > rp_q) && (h_q < q)) ||
			((rp_q >= q) && ((h_q > rp_q) || (h_q < q)));
		st.walk_lim = (kr_q >= CNT_W'(WALK_LIMIT));
		st.ret      = ret_q;
		st.clr_last = (clr_q == '1);
	end

	always_comb begin
		we    = 1'b0;
		waddr = p_q;
		wdata = rd_q;
		raddr = rover_q;
		case (cmd.op)
			OP_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			OP_ALLOC, OP_AR: raddr = rover_q;
			OP_AN: raddr = q;
			OP_AW: begin
				if (st.fit) begin
					we = 1'b1;
					if (st.exact) begin
						waddr = prev_q;
						wdata = '{nxt: q, size: prev_sz_q};
					end else begin
						waddr = p_q;
						wdata = '{nxt: q, size: diff};
						raddr = newp[ADDR_W-1:0];
					end
				end else if (st.at_rover) begin
					raddr = brk_q[ADDR_W-1:0];
				end else begin
					raddr = q;
				end
			end
			OP_S2: begin
				we    = 1'b1;
				waddr = np_q[ADDR_W-1:0];
				wdata = '{nxt: rd_q.nxt, size: n14};
			end
			OP_G2: begin
				we    = 1'b1;
				waddr = h_q;
				wdata = '{nxt: rd_q.nxt, size: nu_q};
			end
			OP_FREE: raddr = ua_q - ADDR_W'(1);
			OP_R0: raddr = h_q;
			OP_R1: raddr = rover_q;
			OP_WALK: raddr = q;
			OP_M2: begin
				we    = 1'b1;
				waddr = h_q;
				wdata = '{nxt: m_next, size: m_size};
			end
			OP_M3: begin
				we    = 1'b1;
				waddr = rp_q;
				if (lo_merge) wdata = '{nxt: hn_q, size: ps_q + hs_q};
				else wdata = '{nxt: h_q, size: ps_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rover_q <= '0;
			clr_q   <= '0;
			brk_q   <= SIZE_W'(1);
			lg_q    <= '0;
			kw_q    <= '0;
			kr_q    <= '0;
			ret_q   <= 1'b0;
			lim_q   <= 1'b0;
		end else begin
			case (cmd.op)
				OP_CLR: clr_q <= clr_q + ADDR_W'(1);
				OP_LOAD: begin
					ret_q <= 1'b0;
					lim_q <= 1'b0;
				end
				OP_ALLOC: kw_q <= '0;
				OP_AW: begin
					if (st.fit) begin
						rover_q <= prev_q;
					end else if (st.at_rover) begin
						if (st.grow_ok) begin
							brk_q <= gsum[SIZE_W-1:0];
							if (nu > lg_q) lg_q <= nu;
							kw_q  <= kw_q + CNT_W'(1);
							lim_q <= st.step_lim;
							ret_q <= 1'b1;
						end
					end else begin
						kw_q <= kw_q + CNT_W'(1);
					end
				end
				OP_R1: kr_q <= '0;
				OP_WALK: if (!st.brk) kr_q <= kr_q + CNT_W'(1);
				OP_M3: rover_q <= rp_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				bytes_q <= in_bytes;
				ua_q    <= in_ua;
				st_q    <= ST_OK;
				ga_q    <= '0;
			end
			OP_ALLOC: begin
				n_q <= nunits;
				if (st.too_big) st_q <= ST_TOO_BIG;
			end
			OP_AN: begin
				prev_q    <= rover_q;
				prev_sz_q <= rd_q.size;
				p_q       <= q;
				if (lim_q) st_q <= ST_OOM;
			end
			OP_AW: begin
				if (st.fit) begin
					np_q <= newp;
					ga_q <= st.exact ? (p_q + ADDR_W'(1)) : (newp[ADDR_W-1:0] + ADDR_W'(1));
				end else if (st.at_rover) begin
					if (st.grow_ok) begin
						h_q  <= brk_q[ADDR_W-1:0];
						nu_q <= nu;
					end else begin
						st_q <= ST_OOM;
					end
				end else begin
					prev_q    <= p_q;
					prev_sz_q <= rd_q.size;
					p_q       <= q;
					if (st.step_lim) st_q <= ST_OOM;
				end
			end
			OP_FREE: begin
				h_q <= ua_q - ADDR_W'(1);
				if (st.zero_ua) st_q <= ST_BAD_FREE;
			end
			OP_R1: begin
				hs_q <= rd_q.size;
				hn_q <= rd_q.nxt;
				rp_q <= rover_q;
				if (st.bad_hdr && !ret_q) st_q <= ST_BAD_FREE;
			end
			OP_WALK: begin
				if (st.brk) begin
					ps_q <= rd_q.size;
					q_q  <= q;
				end else begin
					rp_q <= q;
					if (st.walk_lim && !ret_q) st_q <= ST_BAD_FREE;
				end
			end
			OP_M2: begin
				hs_q <= m_size;
				hn_q <= m_next;
			end
			default: ;
		endcase
		if (cmd.fin) begin
			out_st_q <= st_q;
			out_ga_q <= ga_q;
		end
	end

	assign out_status = out_st_q;
	assign out_addr   = out_ga_q;

endmodule

// File: sv/free_list_heap_allocator.sv
// Heap allocator over a fixed arena of 8192 header units of 16 bytes each.
// Requests arrive on req (action, request_bytes, user_address) and each one
// gives exactly one response on rsp (status, granted_address). Both channels
// use valid/ready; a request is taken when valid and ready are high at a
// rising edge. One request is in service at a time.
// After reset the header memory is cleared, one entry per cycle, and req.ready
// stays low until all 8192 are cleared. Write configuration through the APB port only
// while no request is in service (max_request_bytes at 0x0, min_grow_units
// at 0x4).
// An allocate refused as too big or a zero-address free goes straight to
// the response; a free refused on its header size, after one header read.
// An allocate reads the rover header and visits one free-list header at a
// time in the next-fit search, with one more write for a split; each arena
// growth writes the new header and runs the insertion walk before the
// search goes on. A free visits headers in the address-ordered insertion
// walk, then writes the merged ones. The header memory is read once per cycle.
// The response is held in an output register; if the receiver stalls, the
// next request may still be taken and worked on, but its result waits until
// the previous response has been taken.
module free_list_heap_allocator (
	input  logic              clk,
	input  logic              arst_n,
	flha_req_if.sink          req,
	flha_rsp_if.source        rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import flha_pkg::*;

	logic [BYTES_W-1:0] max_req_q;
	logic [SIZE_W-1:0]  min_grow_q;
	cmd_t               cmd;
	stat_t              st;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_req_q  <= MAX_REQ_RST;
			min_grow_q <= MIN_GROW_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_MAX_REQ:  max_req_q  <= pwdata[BYTES_W-1:0];
				REG_MIN_GROW: min_grow_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MAX_REQ:  prdata = {16'd0, max_req_q};
			REG_MIN_GROW: prdata = {18'd0, min_grow_q};
			default:      prdata = '0;
		endcase
	end

	flha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.st        (st),
		.cmd       (cmd)
	);

	flha_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.in_action  (req.action),
		.in_bytes   (req.request_bytes),
		.in_ua      (req.user_address),
		.max_req    (max_req_q),
		.min_grow   (min_grow_q),
		.out_status (rsp.status),
		.out_addr   (rsp.granted_address)
	);

endmodule

// File: sv/flha_chk.sv
module flha_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  status,
	input logic [12:0] granted_address
);
	import flha_pkg::*;

	// a held response keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(granted_address))
		else $error("response dropped or changed while stalled");

	// failed requests never hand out an address
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != ST_OK) |-> granted_address == '0)
		else $error("address granted on a failed request");

	// one request in service at a time
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while busy");

endmodule

bind free_list_heap_allocator flha_chk u_flha_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.status          (rsp.status),
	.granted_address (rsp.granted_address)
);

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import flha_pkg::*;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;
	localparam int   CYCLE_LIMIT = 50_000_000;
	localparam int   RANDOM_PER_PHASE = 350;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] granted;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	flha_req_if req_ch();
	flha_rsp_if rsp_ch();

	free_list_heap_allocator u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// allocator shadow state
	logic [ADDR_W-1:0] link_mem [HEAP_UNITS];
	logic [SIZE_W-1:0] span_mem [HEAP_UNITS];
	int unsigned rover_idx;
	bit          list_live;
	int unsigned brk_idx;
	int unsigned biggest_chunk;
	int unsigned req_byte_cap;
	int unsigned grow_floor;

	outcome_t    pending_outcomes[$];
	int unsigned held_blocks[$];
	int          mismatches;
	int          send_idle;
	int          recv_idle;
	int          hold_cycles;
	int          cycle_count;

	function automatic int unsigned link_of(int unsigned i);
		return i < HEAP_UNITS ? int'(link_mem[i]) : 0;
	endfunction

	function automatic int unsigned span_of(int unsigned i);
		return i < HEAP_UNITS ? int'(span_mem[i]) : 0;
	endfunction

	function automatic void set_link(int unsigned i, int unsigned v);
		if (i < HEAP_UNITS)
			link_mem[i] = v[ADDR_W-1:0];
	endfunction

	function automatic void set_span(int unsigned i, int unsigned v);
		if (i < HEAP_UNITS)
			span_mem[i] = v[SIZE_W-1:0];
	endfunction

	function automatic bit insert_free(int unsigned hdr);
		int unsigned s;
		int unsigned p;
		int unsigned q;
		int unsigned k;
		if (hdr >= HEAP_UNITS)
			return 0;
		s = span_of(hdr);
		if (s == 0 || s > biggest_chunk)
			return 0;
		p = rover_idx;
		for (k = 0; ; k++) begin
			q = link_of(p);
			if (hdr > p && hdr < q)
				break;
			if (p >= q && (hdr > p || hdr < q))
				break;
			if (k >= WALK_LIMIT)
				return 0;
			p = q;
		end
		q = link_of(p);
		if (hdr + span_of(hdr) == q) begin
			set_span(hdr, span_of(hdr) + span_of(q));
			set_link(hdr, link_of(q));
		end else begin
			set_link(hdr, q);
		end
		if (p + span_of(p) == hdr) begin
			set_span(p, span_of(p) + span_of(hdr));
			set_link(p, link_of(hdr));
		end else begin
			set_link(p, hdr);
		end
		rover_idx = p;
		return 1;
	endfunction

	function automatic bit extend_arena(int unsigned need);
		int unsigned nu;
		int unsigned up;
		nu = need < grow_floor ? grow_floor : need;
		up = brk_idx;
		if (longint'(up) + longint'(nu) > HEAP_UNITS)
			return 0;
		set_span(up, nu);
		brk_idx = up + nu;
		if (nu > biggest_chunk)
			biggest_chunk = nu & 32'h3FFF;
		void'(insert_free(up));
		return 1;
	endfunction

	function automatic outcome_t predict_outcome(logic act, logic [15:0] bytes,
		logic [ADDR_W-1:0] ua);
		outcome_t    o;
		int unsigned units;
		int unsigned prev;
		int unsigned p;
		int unsigned k;
		int unsigned s;
		o = '0;
		if (!list_live) begin
			set_link(0, 0);
			set_span(0, 0);
			rover_idx = 0;
			list_live = 1;
		end
		if (act == ACT_FREE) begin
			if (ua == 0 || !insert_free(int'(ua) - 1))
				o.status = ST_BAD_FREE;
			return o;
		end
		if (bytes > req_byte_cap) begin
			o.status = ST_TOO_BIG;
			return o;
		end
		units = (int'(bytes) + UNIT_BYTES - 1) / UNIT_BYTES + 1;
		prev = rover_idx;
		p = link_of(rover_idx);
		for (k = 0; k < WALK_LIMIT; k++) begin
			s = span_of(p);
			if (s >= units) begin
				if (s == units) begin
					set_link(prev, link_of(p));
				end else begin
					set_span(p, s - units);
					p += s - units;
					set_span(p, units);
				end
				rover_idx = prev;
				o.granted = ADDR_W'(p + 1);
				return o;
			end
			if (p == rover_idx) begin
				if (!extend_arena(units)) begin
					o.status = ST_OOM;
					return o;
				end
				p = rover_idx;
			end
			prev = p;
			p = link_of(p);
		end
		o.status = ST_OOM;
		return o;
	endfunction

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold when asked
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles = hold_cycles - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response status=%0d addr=%0d",
						rsp_ch.status, rsp_ch.granted_address);
			end else begin
				outcome_t want;
				want = pending_outcomes.pop_front();
				if (rsp_ch.status !== want.status || rsp_ch.granted_address !== want.granted) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: status exp %0d got %0d, addr exp %0d got %0d",
							want.status, rsp_ch.status, want.granted,
							rsp_ch.granted_address);
				end
			end
		end
	end

	task automatic issue_request(logic act, logic [15:0] bytes, logic [ADDR_W-1:0] ua);
		outcome_t o;
		while ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.action        <= act;
		req_ch.request_bytes <= bytes;
		req_ch.user_address  <= ua;
		do
			@(posedge clk);
		while (!req_ch.ready);
		o = predict_outcome(act, bytes, ua);
		pending_outcomes.push_back(o);
		if (act == ACT_ALLOC && o.status == ST_OK)
			held_blocks.push_back(o.granted);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_MAX_REQ)
			req_byte_cap = value & 32'hFFFF;
		else
			grow_floor = value & 32'h3FFF;
	endtask

	task automatic free_random_held();
		int unsigned i;
		int unsigned a;
		i = $urandom_range(held_blocks.size() - 1);
		a = held_blocks[i];
		held_blocks.delete(i);
		issue_request(ACT_FREE, 16'($urandom), a[ADDR_W-1:0]);
	endtask

	task automatic test_empty_frees();
		issue_request(ACT_FREE, 16'd0, 13'd5);
		issue_request(ACT_FREE, 16'hFFFF, 13'd0);
	endtask

	// the whole arena goes in one growth, leaving the top unit at user address zero
	task automatic test_arena_growth();
		wait_drained();
		write_reg(REG_MIN_GROW, 32'd8192);
		issue_request(ACT_ALLOC, 16'd16, 13'd0);
		wait_drained();
		write_reg(REG_MIN_GROW, 32'd8191);
		issue_request(ACT_ALLOC, 16'd0, 13'd0);
		issue_request(ACT_ALLOC, 16'd1, 13'd0);
		issue_request(ACT_ALLOC, 16'd17, 13'd0);
	endtask

	task automatic test_request_limit();
		issue_request(ACT_ALLOC, 16'd10240, 13'h1FFF);
		issue_request(ACT_ALLOC, 16'd10241, 13'd0);
		issue_request(ACT_ALLOC, 16'hFFFF, 13'd0);
		wait_drained();
		write_reg(REG_MAX_REQ, 32'd0);
		issue_request(ACT_ALLOC, 16'd0, 13'd0);
		issue_request(ACT_ALLOC, 16'd1, 13'd0);
		wait_drained();
		write_reg(REG_MAX_REQ, 32'hFFFF);
		issue_request(ACT_ALLOC, 16'hFFFF, 13'd0);
		issue_request(ACT_ALLOC, 16'hFFFF, 13'd0);
	endtask

	task automatic test_bad_frees();
		int unsigned a;
		issue_request(ACT_FREE, 16'd0, 13'h1FFF);
		issue_request(ACT_FREE, 16'd0, 13'd1);
		issue_request(ACT_ALLOC, 16'd100, 13'd0);
		a = held_blocks[$];
		held_blocks.delete(held_blocks.size() - 1);
		issue_request(ACT_FREE, 16'd0, a[ADDR_W-1:0]);
		issue_request(ACT_FREE, 16'd0, a[ADDR_W-1:0]);
		while (held_blocks.size() > 0)
			free_random_held();
	endtask

	task automatic run_random(int count);
		int unsigned r;
		int unsigned b;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 10) begin
				issue_request(ACT_FREE, 16'($urandom), 13'($urandom));
			end else if ((r < 50 || held_blocks.size() > 400) && held_blocks.size() > 0) begin
				free_random_held();
			end else begin
				b = $urandom_range(99);
				if (b < 80)
					b = $urandom_range(300);
				else if (b < 95)
					b = $urandom_range(4000);
				else
					b = $urandom_range(16'hFFFF);
				issue_request(ACT_ALLOC, b[15:0], 13'($urandom));
			end
		end
	endtask

	task automatic test_random_phases();
		wait_drained();
		write_reg(REG_MAX_REQ, 32'd4096);
		write_reg(REG_MIN_GROW, 32'd1);
		send_idle = 0;
		recv_idle = 0;
		run_random(RANDOM_PER_PHASE);
		send_idle = 56;
		run_random(RANDOM_PER_PHASE);
		wait_drained();
		write_reg(REG_MAX_REQ, 32'hFFFF);
		send_idle = 0;
		recv_idle = 56;
		run_random(RANDOM_PER_PHASE);
		wait_drained();
		write_reg(REG_MAX_REQ, 32'd10240);
		write_reg(REG_MIN_GROW, 32'd1024);
		send_idle = 6;
		recv_idle = 6;
		run_random(RANDOM_PER_PHASE);
	endtask

	// hold the receiver off while requests keep coming, then let everything drain
	task automatic test_backpressure();
		send_idle = 0;
		recv_idle = 0;
		hold_cycles = 3000;
		run_random(20);
		wait_drained();
		run_random(10);
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		req_ch.valid = 1'b0;
		req_ch.action        = ACT_ALLOC;
		req_ch.request_bytes = '0;
		req_ch.user_address  = '0;
		rsp_ch.ready = 1'b0;
		mismatches   = 0;
		send_idle    = 0;
		recv_idle    = 0;
		hold_cycles  = 0;
		cycle_count  = 0;
		for (int i = 0; i < HEAP_UNITS; i++) begin
			link_mem[i] = '0;
			span_mem[i] = '0;
		end
		rover_idx     = 0;
		list_live     = 0;
		brk_idx       = 1;
		biggest_chunk = 0;
		req_byte_cap  = 10240;
		grow_floor    = 1024;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_frees();
		test_arena_growth();
		test_request_limit();
		test_bad_frees();
		test_random_phases();
		test_backpressure();

		wait_drained();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending_outcomes.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

// File: files.f
sv/flha_pkg.sv
sv/flha_if.sv
sv/flha_ctrl.sv
sv/flha_dp.sv
sv/free_list_heap_allocator.sv
sv/flha_chk.sv
bench/testbench.sv
